[src/snapshot_history_ring_nearest_time_core_defines.svh]
// ----------------------------------------------------------------------------
// snapshot history ring: assertion macros
// shared property wrappers for the checker files
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_HISTORY_RING_NEAREST_TIME_CORE_DEFINES_SVH
`define SNAPSHOT_HISTORY_RING_NEAREST_TIME_CORE_DEFINES_SVH

// property checked only outside reset
`define SHRNT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define SHRNT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/shrnt_pkg.sv]
// ----------------------------------------------------------------------------
// shrnt_pkg
// types, sizes and helpers shared by the snapshot history ring
// ----------------------------------------------------------------------------
package shrnt_pkg;

   localparam int unsigned DEPTH    = 64;
   localparam int unsigned PTR_W    = $clog2(DEPTH);
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned HANDLE_W = 32;
   localparam int unsigned WORD_W   = TIME_W + HANDLE_W;

   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [WORD_W-1:0]   word_type;

   typedef enum logic {
      OP_RECORD   = 1'b0,
      OP_ROLLBACK = 1'b1
   } op_type;

   // ring memory port request
   typedef struct packed {
      logic     we;
      ptr_type  waddr;
      word_type wdata;
      logic     re;
      ptr_type  raddr;
   } mem_req_type;

   function automatic ptr_type ring_next(ptr_type p);
      ptr_type r;
      if (p == ptr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

endpackage

[src/shrnt_if.sv]
// ----------------------------------------------------------------------------
// shrnt channel interfaces
// valid/ready channels for request and response transactions
// ----------------------------------------------------------------------------
interface shrnt_req_if;
   import shrnt_pkg::*;

   logic       valid;
   logic       ready;
   logic       operation;
   time_type   time_stamp;
   handle_type snapshot_handle;

   modport source (output valid, output operation, output time_stamp,
                   output snapshot_handle, input ready);
   modport sink   (input valid, input operation, input time_stamp,
                   input snapshot_handle, output ready);
endinterface

interface shrnt_rsp_if;
   import shrnt_pkg::*;

   logic       valid;
   logic       ready;
   logic       found;
   handle_type chosen_handle;
   time_type   chosen_time;

   modport source (output valid, output found, output chosen_handle,
                   output chosen_time, input ready);
   modport sink   (input valid, input found, input chosen_handle,
                   input chosen_time, output ready);
endinterface

[src/snapshot_history_ring_nearest_time_core.sv]
// A record transaction writes its time and handle into the ring memory at
// the write pointer, and once the ring is full the oldest entry is dropped,
// so at most DEPTH-1 entries are held. A rollback transaction walks the held
// entries from oldest to newest through the single read port of the ring
// memory, one entry per cycle, and keeps the entry whose time is nearest the
// target (the oldest wins a tie); new requests wait until its result is
// loaded into the output register. The result sits in an output register,
// so records are accepted while a response waits to be taken. A rollback
// that finds an entry empties the ring.
// ----------------------------------------------------------------------------
// snapshot_history_ring_nearest_time_core
// timestamped snapshot ring with nearest time rollback
// ----------------------------------------------------------------------------
module snapshot_history_ring_nearest_time_core (
   input  logic        clock,
   input  logic        reset,
   shrnt_req_if.sink   req_chan,
   shrnt_rsp_if.source rsp_chan
);
   import shrnt_pkg::*;

   mem_req_type mem_req;
   word_type    mem_rdata;

   shrnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   shrnt_ring_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

endmodule

[src/shrnt_ring_ram.sv]
// ----------------------------------------------------------------------------
// shrnt_ring_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module shrnt_ring_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/shrnt_ctrl.sv]
// ----------------------------------------------------------------------------
// shrnt_ctrl
// ring pointers, rollback scan pipeline and response register
// ----------------------------------------------------------------------------
module shrnt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   shrnt_req_if.sink             req_chan,
   shrnt_rsp_if.source           rsp_chan,
   output shrnt_pkg::mem_req_type mem_req,
   input  shrnt_pkg::word_type   mem_rdata
);
   import shrnt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   ptr_type   wp_ff, wp_in;
   ptr_type   oldest_ff, oldest_in;
   ptr_type   rd_ptr_ff, rd_ptr_in;
   logic      issue_ff, issue_in;
   logic      issue_first_ff, issue_first_in;
   logic      s1_ff, s1_in;
   logic      s1_first_ff, s1_first_in;
   logic      s2_ff, s2_in;
   logic      s2_first_ff, s2_first_in;
   time_type  gap_ff, gap_in;
   word_type  s2_word_ff, s2_word_in;
   time_type  target_ff, target_in;
   time_type  best_gap_ff, best_gap_in;
   word_type  best_word_ff, best_word_in;
   logic      found_ff, found_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_found_ff, out_found_in;
   word_type  out_word_ff, out_word_in;

   logic      accept;
   logic      out_load;
   ptr_type   wp_next;
   ptr_type   rd_next;
   time_type  rd_time;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign wp_next        = ring_next(wp_ff);
   assign rd_next        = ring_next(rd_ptr_ff);
   assign rd_time        = mem_rdata[WORD_W-1 -: TIME_W];
   assign out_load       = (state_ff == ST_RESULT) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      oldest_in      = oldest_ff;
      rd_ptr_in      = rd_ptr_ff;
      issue_in       = issue_ff;
      issue_first_in = issue_first_ff;
      target_in      = target_ff;
      found_in       = found_ff;
      mem_req.we     = 1'b0;
      mem_req.waddr  = wp_ff;
      mem_req.wdata  = {req_chan.time_stamp, req_chan.snapshot_handle};
      mem_req.re     = 1'b0;
      mem_req.raddr  = rd_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.operation == OP_RECORD)) begin
               mem_req.we = 1'b1;
               wp_in      = wp_next;
               // full ring drops its oldest entry
               if (wp_next == oldest_ff) begin
                  oldest_in = ring_next(oldest_ff);
               end
            end else if (accept) begin
               target_in = req_chan.time_stamp;
               if (oldest_ff == wp_ff) begin
                  found_in = 1'b0;
                  state_in = ST_RESULT;
               end else begin
                  found_in       = 1'b1;
                  rd_ptr_in      = oldest_ff;
                  issue_in       = 1'b1;
                  issue_first_in = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               mem_req.re     = 1'b1;
               rd_ptr_in      = rd_next;
               issue_first_in = 1'b0;
               if (rd_next == wp_ff) begin
                  issue_in = 1'b0;
               end
            end else if (!s1_ff && !s2_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_load) begin
               state_in = ST_IDLE;
               if (found_ff) begin
                  wp_in     = '0;
                  oldest_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // scan pipeline: read data, distance, running best
   always_comb begin
      s1_in        = issue_ff && (state_ff == ST_SCAN);
      s1_first_in  = issue_first_ff;
      s2_in        = s1_ff;
      s2_first_in  = s1_first_ff;
      s2_word_in   = mem_rdata;
      gap_in       = (target_ff >= rd_time) ? (target_ff - rd_time) : (rd_time - target_ff);
      best_gap_in  = best_gap_ff;
      best_word_in = best_word_ff;
      // strict compare keeps the oldest entry on ties
      if (s2_ff && (s2_first_ff || (gap_ff < best_gap_ff))) begin
         best_gap_in  = gap_ff;
         best_word_in = s2_word_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_word_in  = out_word_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_found_in = found_ff;
         out_word_in  = found_ff ? best_word_ff : '0;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.found         = out_found_ff;
   assign rsp_chan.chosen_time   = out_word_ff[WORD_W-1 -: TIME_W];
   assign rsp_chan.chosen_handle = out_word_ff[HANDLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         oldest_ff    <= '0;
         issue_ff     <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         oldest_ff    <= oldest_in;
         issue_ff     <= issue_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff      <= rd_ptr_in;
      issue_first_ff <= issue_first_in;
      s1_first_ff    <= s1_first_in;
      s2_first_ff    <= s2_first_in;
      gap_ff         <= gap_in;
      s2_word_ff     <= s2_word_in;
      target_ff      <= target_in;
      best_gap_ff    <= best_gap_in;
      best_word_ff   <= best_word_in;
      found_ff       <= found_in;
      out_found_ff   <= out_found_in;
      out_word_ff    <= out_word_in;
   end

endmodule

[src/shrnt_checker.sv]
// ----------------------------------------------------------------------------
// shrnt_checker
// port level checks for the snapshot history ring
// ----------------------------------------------------------------------------
`include "snapshot_history_ring_nearest_time_core_defines.svh"

module shrnt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_found,
   input shrnt_pkg::handle_type  rsp_chosen_handle,
   input shrnt_pkg::time_type    rsp_chosen_time
);
   import shrnt_pkg::*;

   // a stalled response holds its transaction
   `SHRNT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_chosen_handle) && $stable(rsp_chosen_time), "response changed while stalled")

   `SHRNT_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "response valid after reset")

   // an accepted rollback keeps the block busy, with request ready low
   `SHRNT_ASSERT(a_rollback_busy, clock, reset, req_valid && req_ready && (req_operation == OP_ROLLBACK) |=> !req_ready, "request taken right after rollback")

   `SHRNT_ASSERT(a_empty_zero, clock, reset, rsp_valid && !rsp_found |-> (rsp_chosen_handle == '0) && (rsp_chosen_time == '0), "empty ring response not zero")

endmodule

bind snapshot_history_ring_nearest_time_core shrnt_checker u_shrnt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_operation     (req_chan.operation),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_found         (rsp_chan.found),
   .rsp_chosen_handle (rsp_chan.chosen_handle),
   .rsp_chosen_time   (rsp_chan.chosen_time)
);
